>>> hw/rtl/lsc_pkg.sv
// shared types and constants for the loop stack controller
// no dependencies; imported by the stack, the output stage and the top level
`default_nettype none

package lsc_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned NEST_W    = 4;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // request kinds carried on in_tuser
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_END   = 1'b1;

  typedef struct packed {
    logic              push_ok;
    logic              jump_back;
    logic [ADDR_W-1:0] jump_target;
    logic [NEST_W-1:0] nesting_level;
  } lsc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsc_stack.sv
// loop stack: top entry in registers, lower entries in a small memory with a
// registered read of the entry under the top; depends on lsc_pkg
`default_nettype none

module lsc_stack
  import lsc_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_en,
  input  wire logic              req_type,
  input  wire logic [ADDR_W-1:0] loop_start,
  input  wire logic [CNT_W-1:0]  loop_count,
  output lsc_result_t            res
);

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [ADDR_W-1:0] top_addr_r, top_addr_nxt;
  logic [CNT_W-1:0]  top_cnt_r, top_cnt_nxt;
  logic [ADDR_W-1:0] below_addr_r;
  logic [CNT_W-1:0]  below_cnt_r;

  logic [ADDR_W-1:0] addr_mem [MAX_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [MAX_DEPTH];

  logic              full, empty, wr_en;
  logic [IDX_W-1:0]  wr_idx, rd_idx;

  assign full  = (level_r == LVL_W'(MAX_DEPTH));
  assign empty = (level_r == '0);

  always_comb begin
    level_nxt    = level_r;
    top_addr_nxt = top_addr_r;
    top_cnt_nxt  = top_cnt_r;
    wr_en        = 1'b0;
    res          = '0;
    if (req_en) begin
      if (req_type == REQ_BEGIN) begin
        if (!full) begin
          // old top moves down into the memory
          wr_en        = !empty;
          top_addr_nxt = loop_start;
          top_cnt_nxt  = loop_count;
          level_nxt    = level_r + LVL_W'(1);
          res.push_ok  = 1'b1;
        end
      end else if (!empty) begin
        if (top_cnt_r == CNT_W'(0)) begin
          res.jump_back   = 1'b1;
          res.jump_target = top_addr_r;
        end else if (top_cnt_r == CNT_W'(1)) begin
          top_addr_nxt = below_addr_r;
          top_cnt_nxt  = below_cnt_r;
          level_nxt    = level_r - LVL_W'(1);
        end else begin
          top_cnt_nxt     = top_cnt_r - CNT_W'(1);
          res.jump_back   = 1'b1;
          res.jump_target = top_addr_r;
        end
      end
    end
    res.nesting_level = NEST_W'(level_nxt);
  end

  // entry under the new top lives at level - 2
  assign wr_idx = IDX_W'(level_r - LVL_W'(1));
  assign rd_idx = IDX_W'(level_nxt - LVL_W'(2));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= top_addr_r;
      cnt_mem[wr_idx]  <= top_cnt_r;
    end
    // write-first forwarding when a push lands on the prefetched slot
    if (wr_en && (wr_idx == rd_idx)) begin
      below_addr_r <= top_addr_r;
      below_cnt_r  <= top_cnt_r;
    end else begin
      below_addr_r <= addr_mem[rd_idx];
      below_cnt_r  <= cnt_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_addr_r <= top_addr_nxt;
    top_cnt_r  <= top_cnt_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lsc_out_stage.sv
// result register with ready-based flow control toward the result channel
// depends on lsc_pkg
`default_nettype none

module lsc_out_stage
  import lsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load_valid,
  output logic        load_ready,
  input  wire lsc_result_t load_res,
  output logic        res_valid,
  input  wire logic   res_ready,
  output lsc_result_t res_data
);

  logic        valid_r, valid_nxt;
  lsc_result_t data_r;

  // a new result may enter when none is held or when the held one leaves in the same cycle
  assign load_ready = !valid_r || res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data_r <= load_res;
    end
  end

  assign res_valid = valid_r;
  assign res_data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/loop_stack_controller_unit.sv
// top level of the loop stack controller: stack plus result register
// depends on lsc_pkg, lsc_stack and lsc_out_stage
//
// channel   | direction | contents
// in_       | slave     | tuser: req_type; tdata: loop_start, loop_count
// out_      | master    | tdata: push_ok, jump_back, jump_target, nesting_level
//
// one request is taken per cycle unless stalled; its result is in the output
// register in the cycle after acceptance, set by the single stack update path
// in_tready drops only while a result is held and out_tready is low
// rst_n empties the stack and clears the output valid; stack entries need
// no clearing since only entries below the level are ever read
`default_nettype none

module loop_stack_controller_unit
  import lsc_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // loop_start[15:0], loop_count[23:16]
  input  wire logic                  in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // push_ok[0], jump_back[1],
                                                 // jump_target[17:2],
                                                 // nesting_level[21:18], zero[23:22]
);

  logic        req_en;
  lsc_result_t step_res;
  lsc_result_t held_res;

  assign req_en = in_tvalid && in_tready;

  lsc_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_en     (req_en),
    .req_type   (in_tuser),
    .loop_start (in_tdata[ADDR_W-1:0]),
    .loop_count (in_tdata[ADDR_W+CNT_W-1:ADDR_W]),
    .res        (step_res)
  );

  lsc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_ready (in_tready),
    .load_res   (step_res),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (held_res)
  );

  assign out_tdata = {2'b00, held_res.nesting_level, held_res.jump_target,
                      held_res.jump_back, held_res.push_ok};

endmodule

`default_nettype wire

>>> hw/rtl/lsc_checker.sv
// port-level checks for the loop stack controller, bound to the top level
// depends on loop_stack_controller_unit port names
`default_nettype none

module lsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a request never both pushes and jumps
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("push_ok and jump_back both set");

  // no jump means a zero target
  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[17:2] == 16'h0000)
    else $error("jump_target nonzero without jump");

  // an accepted push leaves at least one active loop
  a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[21:18] != 4'h0)
    else $error("push accepted with empty stack");

  // an accepted begin request yields a result that reports no jump
  a_begin_nojump: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> out_tvalid && !out_tdata[1])
    else $error("begin request produced a jump");

endmodule

bind loop_stack_controller_unit lsc_checker u_lsc_checker (.*);

`default_nettype wire

>>> bench/loop_stack_controller_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for loop_stack_controller_unit: directed and random begin/end
// requests, each result compared with a behavioral loop stack kept in the bench
// depends on lsc_pkg and the loop_stack_controller_unit rtl

module loop_stack_controller_unit_tb;
  import lsc_pkg::*;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int IDLE_PCT     = 23;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTS   = 60;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = REQ_BEGIN;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // bench copy of the loop stack
  logic [ADDR_W-1:0] loop_starts [STACK_DEPTH];
  logic [CNT_W-1:0]  loops_left  [STACK_DEPTH];
  int unsigned       active_loops = 0;

  lsc_result_t pending_results [$];
  int unsigned mismatch_count = 0;
  bit          src_gaps_on    = 1'b1;
  bit          sink_gaps_on   = 1'b1;
  int unsigned sink_hold_req  = 0;
  int unsigned sink_hold_left = 0;
  int unsigned quiet_cycles   = 0;

  loop_stack_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic lsc_result_t step_loop_stack(logic kind, logic [ADDR_W-1:0] addr,
                                                  logic [CNT_W-1:0] cnt);
    lsc_result_t res;
    int unsigned top;
    res = '0;
    if (kind == REQ_BEGIN) begin
      if (active_loops < STACK_DEPTH) begin
        loop_starts[active_loops] = addr;
        loops_left[active_loops]  = cnt;
        active_loops++;
        res.push_ok = 1'b1;
      end
    end else if (active_loops > 0) begin
      top = active_loops - 1;
      if (loops_left[top] == 1) begin
        active_loops--;
      end else begin
        // zero means forever, so it is never decremented
        if (loops_left[top] != 0) loops_left[top] = loops_left[top] - 1'b1;
        res.jump_back   = 1'b1;
        res.jump_target = loop_starts[top];
      end
    end
    res.nesting_level = active_loops[NEST_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(logic kind, logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = 0;
    // each idle cycle is added with chance IDLE_PCT, so about IDLE_PCT of the cycles are idle
    while (src_gaps_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {cnt, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(step_loop_stack(kind, addr, cnt));
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request(bit allow_forever);
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    int unsigned       pick;
    addr = ADDR_W'($urandom());
    cnt  = CNT_W'($urandom());
    pick = $urandom_range(99);
    if (active_loops == 0) kind = (pick < 90) ? REQ_BEGIN : REQ_END;
    else if (active_loops >= STACK_DEPTH) kind = (pick < 15) ? REQ_BEGIN : REQ_END;
    else kind = (pick < 42) ? REQ_BEGIN : REQ_END;
    // live pushes get mostly short trip counts so the stack keeps moving;
    // end requests and refused pushes keep their random fields
    if (kind == REQ_BEGIN && active_loops < STACK_DEPTH) begin
      pick = $urandom_range(99);
      if (allow_forever && pick < 15) cnt = '0;
      else if (pick < 99) cnt = CNT_W'($urandom_range(6, 1));
      else cnt = CNT_W'($urandom_range(255, 7));
    end
    send_request(kind, addr, cnt);
  endtask

  task automatic test_empty_stack_end();
    send_request(REQ_END, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_push_and_count();
    send_request(REQ_BEGIN, 16'hFFFF, 8'd2);
    send_request(REQ_BEGIN, 16'h0000, 8'd1);
    send_request(REQ_END, 16'h0000, 8'h00);
    send_request(REQ_END, 16'h5A5A, 8'hA5);
    send_request(REQ_END, 16'h0000, 8'h00);
  endtask

  task automatic test_stack_overflow();
    for (int i = 0; i < STACK_DEPTH; i++)
      send_request(REQ_BEGIN, ADDR_W'(16'h1111 * (i + 1)), 8'd1);
    send_request(REQ_BEGIN, 16'hFFFF, 8'hFF);
    send_request(REQ_BEGIN, 16'h0000, 8'h00);
    repeat (STACK_DEPTH) send_request(REQ_END, 16'h0000, 8'h00);
  endtask

  task automatic test_random_nesting(int unsigned n);
    repeat (n) send_random_request(1'b0);
  endtask

  task automatic test_full_rate();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (150) send_random_request(1'b0);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    // the sink stalls on its own while requests keep coming
    sink_hold_req = HOLD_CYCLES;
    repeat (40) send_random_request(1'b0);
  endtask

  task automatic test_drain_pause();
    repeat (60) send_random_request(1'b0);
    stop_sending();
    wait_results_drained();
    repeat (60) send_random_request(1'b0);
  endtask

  task automatic test_forever_loops();
    // forever entries never pop, so this runs last
    send_request(REQ_BEGIN, 16'h4321, 8'h00);
    send_request(REQ_END, 16'hFFFF, 8'hFF);
    send_request(REQ_END, 16'h0000, 8'h00);
    repeat (150) send_random_request(1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack_end();
    test_push_and_count();
    test_stack_overflow();
    test_random_nesting(500);
    test_full_rate();
    test_output_backpressure();
    test_drain_pause();
    test_forever_loops();
    stop_sending();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (sink_hold_req != 0) begin
        sink_hold_left = sink_hold_req;
        sink_hold_req  = 0;
      end
      if (sink_hold_left != 0) begin
        sink_hold_left--;
        out_tready <= 1'b0;
      end else if (sink_gaps_on) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // out_tdata: push_ok, jump_back, jump_target, nesting_level, pad, from bit 0 up
  always @(posedge clk) begin
    lsc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_tdata), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.push_ok)
          report_mismatch("push_ok", 32'(out_tdata[0]), 32'(want.push_ok));
        if (out_tdata[1] !== want.jump_back)
          report_mismatch("jump_back", 32'(out_tdata[1]), 32'(want.jump_back));
        if (out_tdata[17:2] !== want.jump_target)
          report_mismatch("jump_target", 32'(out_tdata[17:2]), 32'(want.jump_target));
        if (out_tdata[21:18] !== want.nesting_level)
          report_mismatch("nesting_level", 32'(out_tdata[21:18]), 32'(want.nesting_level));
        if (out_tdata[OUT_DATA_W-1:22] !== '0)
          report_mismatch("pad bits", 32'(out_tdata[OUT_DATA_W-1:22]), 32'h0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

>>> filelist.f
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_stack.sv
hw/rtl/lsc_out_stage.sv
hw/rtl/loop_stack_controller_unit.sv
hw/rtl/lsc_checker.sv
bench/loop_stack_controller_unit_tb.sv
